[src/nms_pkg.sv]
// shared types, register map and constants for the navigation mode supervisor
`timescale 1ns / 1ps
`default_nettype none

package nms_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DIST_W      = 16;
   localparam int AZ_W        = 13;
   localparam int AZ_LIMIT_W  = 12;
   localparam int TICK_W      = 16;

   localparam logic [DIST_W-1:0] NO_READING = {DIST_W{1'b1}};
   localparam logic [TICK_W-1:0] TICK_MAX   = {TICK_W{1'b1}};

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRONT_BLOCK   = 3'd0,
      CSR_FRONT_RELEASE = 3'd1,
      CSR_SIDE_BLOCK    = 3'd2,
      CSR_ESTOP         = 3'd3,
      CSR_REJOIN_TOL    = 3'd4,
      CSR_AZ_LIMIT      = 3'd5,
      CSR_POSE_TIMEOUT  = 3'd6,
      CSR_RELEASE_HOLD  = 3'd7
   } csr_index_type;

   localparam logic [DIST_W-1:0]     RST_FRONT_BLOCK   = 16'd700;
   localparam logic [DIST_W-1:0]     RST_FRONT_RELEASE = 16'd850;
   localparam logic [DIST_W-1:0]     RST_SIDE_BLOCK    = 16'd500;
   localparam logic [DIST_W-1:0]     RST_ESTOP         = 16'd300;
   localparam logic [DIST_W-1:0]     RST_REJOIN_TOL    = 16'd300;
   localparam logic [AZ_LIMIT_W-1:0] RST_AZ_LIMIT      = 12'd524;
   localparam logic [TICK_W-1:0]     RST_POSE_TIMEOUT  = 16'd25;
   localparam logic [TICK_W-1:0]     RST_RELEASE_HOLD  = 16'd25;

   // local path events
   typedef enum logic [1:0] {
      LP_NONE      = 2'd0,
      LP_NEW_PATH  = 2'd1,
      LP_NEW_EMPTY = 2'd2,
      LP_RESERVED  = 2'd3
   } lp_event_type;

   typedef enum logic [3:0] {
      MODE_WAIT      = 4'd0,
      MODE_TRACK     = 4'd1,
      MODE_PLAN      = 4'd2,
      MODE_FOLLOW    = 4'd3,
      MODE_REJOIN    = 4'd4,
      MODE_OBST_STOP = 4'd5,
      MODE_GOAL      = 4'd6,
      MODE_ESTOP     = 4'd7,
      MODE_LOST      = 4'd8
   } nav_mode_type;

   typedef struct packed {
      logic [DIST_W-1:0]     front_block_mm;
      logic [DIST_W-1:0]     front_release_mm;
      logic [DIST_W-1:0]     side_block_mm;
      logic [DIST_W-1:0]     estop_mm;
      logic [DIST_W-1:0]     rejoin_tol_mm;
      logic [AZ_LIMIT_W-1:0] azimuth_limit_mrad;
      logic [TICK_W-1:0]     pose_timeout_ticks;
      logic [TICK_W-1:0]     release_hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic                   pose_arrived;
      logic                   path_ok;
      logic                   at_goal;
      logic signed [AZ_W-1:0] front_azimuth_mrad;
      logic [DIST_W-1:0]      front_dist_mm;
      logic [DIST_W-1:0]      left_dist_mm;
      logic [DIST_W-1:0]      right_dist_mm;
      logic                   free_space_ok;
      logic [1:0]             local_path_event;
      logic [DIST_W-1:0]      dist_to_path_mm;
   } req_beat_type;

   typedef struct packed {
      nav_mode_type nav_mode;
      logic         front_obstructed;
      logic         left_obstructed;
      logic         right_obstructed;
      logic         want_local_path;
      logic         want_rejoin;
      logic         want_stop;
   } rsp_beat_type;

endpackage

`default_nettype wire

[src/nms_channels.sv]
// valid/ready channel interfaces for request, response and register writes
`timescale 1ns / 1ps
`default_nettype none

interface nms_req_if;
   import nms_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   pose_arrived;
   logic                   path_ok;
   logic                   at_goal;
   logic signed [AZ_W-1:0] front_azimuth_mrad;
   logic [DIST_W-1:0]      front_dist_mm;
   logic [DIST_W-1:0]      left_dist_mm;
   logic [DIST_W-1:0]      right_dist_mm;
   logic                   free_space_ok;
   logic [1:0]             local_path_event;
   logic [DIST_W-1:0]      dist_to_path_mm;

   modport source (
      output valid, pose_arrived, path_ok, at_goal, front_azimuth_mrad,
             front_dist_mm, left_dist_mm, right_dist_mm, free_space_ok,
             local_path_event, dist_to_path_mm,
      input  ready
   );
   modport sink (
      input  valid, pose_arrived, path_ok, at_goal, front_azimuth_mrad,
             front_dist_mm, left_dist_mm, right_dist_mm, free_space_ok,
             local_path_event, dist_to_path_mm,
      output ready
   );
endinterface

interface nms_rsp_if;
   import nms_pkg::*;
   logic       valid;
   logic       ready;
   logic [3:0] nav_mode;
   logic       front_obstructed;
   logic       left_obstructed;
   logic       right_obstructed;
   logic       want_local_path;
   logic       want_rejoin;
   logic       want_stop;

   modport source (
      output valid, nav_mode, front_obstructed, left_obstructed, right_obstructed,
             want_local_path, want_rejoin, want_stop,
      input  ready
   );
   modport sink (
      input  valid, nav_mode, front_obstructed, left_obstructed, right_obstructed,
             want_local_path, want_rejoin, want_stop,
      output ready
   );
endinterface

interface nms_csr_if;
   import nms_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/nms_csr_regs.sv]
// configuration register file with reset defaults
`timescale 1ns / 1ps
`default_nettype none

module nms_csr_regs (
   input  wire logic     clock,
   input  wire logic     reset,
   nms_csr_if.sink       csr_ch,
   output nms_pkg::cfg_type cfg
);
   import nms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_FRONT_BLOCK:   cfg_in.front_block_mm     = csr_ch.data;
            CSR_FRONT_RELEASE: cfg_in.front_release_mm   = csr_ch.data;
            CSR_SIDE_BLOCK:    cfg_in.side_block_mm      = csr_ch.data;
            CSR_ESTOP:         cfg_in.estop_mm           = csr_ch.data;
            CSR_REJOIN_TOL:    cfg_in.rejoin_tol_mm      = csr_ch.data;
            CSR_AZ_LIMIT:      cfg_in.azimuth_limit_mrad = csr_ch.data[AZ_LIMIT_W-1:0];
            CSR_POSE_TIMEOUT:  cfg_in.pose_timeout_ticks = csr_ch.data;
            CSR_RELEASE_HOLD:  cfg_in.release_hold_ticks = csr_ch.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_block_mm     <= RST_FRONT_BLOCK;
         cfg_ff.front_release_mm   <= RST_FRONT_RELEASE;
         cfg_ff.side_block_mm      <= RST_SIDE_BLOCK;
         cfg_ff.estop_mm           <= RST_ESTOP;
         cfg_ff.rejoin_tol_mm      <= RST_REJOIN_TOL;
         cfg_ff.azimuth_limit_mrad <= RST_AZ_LIMIT;
         cfg_ff.pose_timeout_ticks <= RST_POSE_TIMEOUT;
         cfg_ff.release_hold_ticks <= RST_RELEASE_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[src/nms_core.sv]
// mode decision, front hysteresis and per-tick state
`timescale 1ns / 1ps
`default_nettype none

module nms_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire nms_pkg::req_beat_type req_beat,
   input  wire nms_pkg::cfg_type      cfg,
   output nms_pkg::rsp_beat_type      rsp_beat
);
   import nms_pkg::*;

   logic [TICK_W-1:0] pose_idle_ff, pose_idle_in;
   logic              blocked_ff, blocked_in;
   logic              release_active_ff, release_active_in;
   logic [TICK_W-1:0] release_count_ff, release_count_in;
   nav_mode_type      prev_mode_ff, prev_mode_in;
   logic              path_held_ff, path_held_in;

   logic              lost;
   logic              held_evt;
   logic [AZ_W-1:0]   az_bits;
   logic [AZ_W-1:0]   az_mag;
   logic              in_sector;
   logic              have_clear;
   logic              estop;
   logic              run_hyst;
   logic              clear_tick;
   logic [TICK_W-1:0] count_eff;
   logic              h_blocked;
   logic              h_active;
   logic [TICK_W-1:0] h_count;
   logic              h_held;
   nav_mode_type      mode;

   always_comb begin
      // pose age, saturating
      if (req_beat.pose_arrived) begin
         pose_idle_in = '0;
      end else if (pose_idle_ff == TICK_MAX) begin
         pose_idle_in = pose_idle_ff;
      end else begin
         pose_idle_in = pose_idle_ff + TICK_W'(1);
      end
      lost = pose_idle_in > cfg.pose_timeout_ticks;

      unique case (lp_event_type'(req_beat.local_path_event))
         LP_NEW_PATH:  held_evt = 1'b1;
         LP_NEW_EMPTY: held_evt = 1'b0;
         LP_NONE,
         LP_RESERVED:  held_evt = path_held_ff;
      endcase

      // front sector test on the bearing magnitude
      az_bits    = req_beat.front_azimuth_mrad;
      az_mag     = az_bits[AZ_W-1] ? (~az_bits + AZ_W'(1)) : az_bits;
      in_sector  = az_mag <= {1'b0, cfg.azimuth_limit_mrad};
      have_clear = (req_beat.front_dist_mm != NO_READING) && in_sector;
      estop      = have_clear && (req_beat.front_dist_mm < cfg.estop_mm);

      run_hyst = !lost && req_beat.path_ok && !estop && !req_beat.at_goal;

      // front hysteresis with release hold
      h_blocked  = blocked_ff;
      h_active   = release_active_ff;
      h_count    = release_count_ff;
      h_held     = held_evt;
      clear_tick = !have_clear || (req_beat.front_dist_mm > cfg.front_release_mm);
      count_eff  = release_active_ff ? release_count_ff : '0;
      if (!blocked_ff) begin
         if (have_clear && (req_beat.front_dist_mm < cfg.front_block_mm)) begin
            h_blocked = 1'b1;
            h_active  = 1'b0;
         end
      end else if (clear_tick) begin
         h_active = 1'b1;
         h_count  = count_eff;
         if (count_eff >= cfg.release_hold_ticks) begin
            h_blocked = 1'b0;
            h_active  = 1'b0;
            h_held    = 1'b0;
         end else if (count_eff != TICK_MAX) begin
            h_count = count_eff + TICK_W'(1);
         end
      end else begin
         h_active = 1'b0;
      end

      if (run_hyst) begin
         blocked_in        = h_blocked;
         release_active_in = h_active;
         release_count_in  = h_count;
         path_held_in      = h_held;
      end else begin
         blocked_in        = blocked_ff;
         release_active_in = release_active_ff;
         release_count_in  = release_count_ff;
         path_held_in      = held_evt;
      end

      priority if (lost) begin
         mode = MODE_LOST;
      end else if (!req_beat.path_ok) begin
         mode = MODE_WAIT;
      end else if (estop) begin
         mode = MODE_ESTOP;
      end else if (req_beat.at_goal) begin
         mode = MODE_GOAL;
      end else if (h_blocked) begin
         if (!req_beat.free_space_ok) begin
            mode = MODE_OBST_STOP;
         end else begin
            mode = h_held ? MODE_FOLLOW : MODE_PLAN;
         end
      end else if (((prev_mode_ff == MODE_PLAN) || (prev_mode_ff == MODE_FOLLOW)) &&
                   (req_beat.dist_to_path_mm < cfg.rejoin_tol_mm)) begin
         mode = MODE_REJOIN;
      end else begin
         mode = MODE_TRACK;
      end
      prev_mode_in = mode;

      rsp_beat.nav_mode         = mode;
      rsp_beat.front_obstructed = blocked_in;
      rsp_beat.left_obstructed  = (req_beat.left_dist_mm != NO_READING) &&
                                  (req_beat.left_dist_mm < cfg.side_block_mm);
      rsp_beat.right_obstructed = (req_beat.right_dist_mm != NO_READING) &&
                                  (req_beat.right_dist_mm < cfg.side_block_mm);
      rsp_beat.want_local_path  = (mode == MODE_PLAN) || (mode == MODE_FOLLOW);
      rsp_beat.want_rejoin      = mode == MODE_REJOIN;
      rsp_beat.want_stop        = (mode == MODE_OBST_STOP) || (mode == MODE_GOAL) ||
                                  (mode == MODE_ESTOP) || (mode == MODE_LOST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_idle_ff      <= '0;
         blocked_ff        <= 1'b0;
         release_active_ff <= 1'b0;
         release_count_ff  <= '0;
         prev_mode_ff      <= MODE_WAIT;
         path_held_ff      <= 1'b0;
      end else if (step) begin
         pose_idle_ff      <= pose_idle_in;
         blocked_ff        <= blocked_in;
         release_active_ff <= release_active_in;
         release_count_ff  <= release_count_in;
         prev_mode_ff      <= prev_mode_in;
         path_held_ff      <= path_held_in;
      end
   end

   // release hold only runs while the front is flagged blocked
   assert property (@(posedge clock) disable iff (reset)
      release_active_ff |-> blocked_ff)
      else $error("release hold active without blocked flag");

   // a fresh pose can never leave localization lost
   assert property (@(posedge clock) disable iff (reset)
      step && req_beat.pose_arrived |-> mode != MODE_LOST)
      else $error("lost reported on a tick with a fresh pose");

   // rejoin only follows a local path mode
   assert property (@(posedge clock) disable iff (reset)
      step && (mode == MODE_REJOIN) |=> $past(prev_mode_ff) == MODE_PLAN ||
                                        $past(prev_mode_ff) == MODE_FOLLOW)
      else $error("rejoin without a preceding local path mode");

   // blocked handling modes leave the blocked flag set
   assert property (@(posedge clock) disable iff (reset)
      step && ((mode == MODE_OBST_STOP) || (mode == MODE_PLAN) || (mode == MODE_FOLLOW))
      |=> blocked_ff)
      else $error("blocked handling mode with front flag clear");

endmodule

`default_nettype wire

[src/navigation_mode_supervisor.sv]
// top level: request register, mode decision and response register
// an accepted beat goes to the request register, its result to the response register
// throughput: one beat per cycle unless the response stalls and is held in its register
// the request register refills while the response register drains in the same cycle
// reset clears all tick state, loads the default thresholds and empties both registers
`timescale 1ns / 1ps
`default_nettype none

module navigation_mode_supervisor (
   input  wire logic clock,
   input  wire logic reset,
   nms_req_if.sink   req_ch,
   nms_rsp_if.source rsp_ch,
   nms_csr_if.sink   csr_ch
);
   import nms_pkg::*;

   cfg_type      cfg;
   req_beat_type req_beat;
   req_beat_type in_beat_ff, in_beat_in;
   logic         in_valid_ff, in_valid_in;
   rsp_beat_type core_beat;
   rsp_beat_type out_beat_ff, out_beat_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance;
   logic         req_take;

   nms_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   nms_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_beat (in_beat_ff),
      .cfg      (cfg),
      .rsp_beat (core_beat)
   );

   always_comb begin
      req_beat.pose_arrived       = req_ch.pose_arrived;
      req_beat.path_ok            = req_ch.path_ok;
      req_beat.at_goal            = req_ch.at_goal;
      req_beat.front_azimuth_mrad = req_ch.front_azimuth_mrad;
      req_beat.front_dist_mm      = req_ch.front_dist_mm;
      req_beat.left_dist_mm       = req_ch.left_dist_mm;
      req_beat.right_dist_mm      = req_ch.right_dist_mm;
      req_beat.free_space_ok      = req_ch.free_space_ok;
      req_beat.local_path_event   = req_ch.local_path_event;
      req_beat.dist_to_path_mm    = req_ch.dist_to_path_mm;
   end

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_beat_in  = req_take ? req_beat : in_beat_ff;
      in_valid_in = req_take || (in_valid_ff && !advance);
      out_beat_in = advance ? core_beat : out_beat_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_beat_ff  <= in_beat_in;
      out_beat_ff <= out_beat_in;
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.nav_mode         = out_beat_ff.nav_mode;
   assign rsp_ch.front_obstructed = out_beat_ff.front_obstructed;
   assign rsp_ch.left_obstructed  = out_beat_ff.left_obstructed;
   assign rsp_ch.right_obstructed = out_beat_ff.right_obstructed;
   assign rsp_ch.want_local_path  = out_beat_ff.want_local_path;
   assign rsp_ch.want_rejoin      = out_beat_ff.want_rejoin;
   assign rsp_ch.want_stop        = out_beat_ff.want_stop;

endmodule

`default_nettype wire
